### rtl/sfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the sync frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

   localparam int MAX_LEN_DEFAULT = 32;

   localparam int BYTE_W   = 8;
   localparam int FLEN_W   = 6;
   localparam int BIDX_W   = 5;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND = 1'd1;

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   typedef enum logic [2:0] {
      PH_SYNC1,
      PH_SYNC2,
      PH_TYPE,
      PH_LEN,
      PH_PAYLOAD,
      PH_CHECK,
      PH_READ,
      PH_LOAD
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_first;
      logic [BYTE_W-1:0] sync_second;
   } cfg_type;

endpackage
`default_nettype wire

### rtl/sync_frame_decoder_xor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_frame_decoder_xor
// Two-byte sync frame receiver with XOR check byte and payload replay.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  req_    | in  | req_valid / req_ready  | rx_byte
//  rsp_    | out | rsp_valid / rsp_ready  | status, frame_type, frame_length,
//          |     |                        | has_data, byte_index, payload_byte, last
//  csr_    | in  | csr_we                 | csr_index, csr_wdata
//
//  Header and payload bytes: one transaction per cycle; payload goes to the RAM.
//  Check byte: accepted once the result register is free.
//  Replay: per payload byte a RAM read, then a result load once the result register is free, input held off.
//  Reset clears the parser and the result valid; the RAM needs no clearing.
//  A stalled result holds the header input only at the check byte or in replay.
module sync_frame_decoder_xor #(
   parameter int MAX_LEN = sfd_pkg::MAX_LEN_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [sfd_pkg::BYTE_W-1:0]    req_rx_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_status,
   output logic [sfd_pkg::BYTE_W-1:0]         rsp_frame_type,
   output logic [sfd_pkg::FLEN_W-1:0]         rsp_frame_length,
   output logic                               rsp_has_data,
   output logic [sfd_pkg::BIDX_W-1:0]         rsp_byte_index,
   output logic [sfd_pkg::BYTE_W-1:0]         rsp_payload_byte,
   output logic                               rsp_last,
   input  wire logic                          csr_we,
   input  wire logic [sfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sfd_pkg::BYTE_W-1:0]    csr_wdata
);

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   sfd_pkg::cfg_type           cfg_ff, cfg_in;
   logic                       ram_we;
   logic                       ram_re;
   logic [AW-1:0]              ram_addr;
   logic [sfd_pkg::BYTE_W-1:0] ram_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            sfd_pkg::CSR_SYNC_FIRST:  cfg_in.sync_first  = csr_wdata;
            sfd_pkg::CSR_SYNC_SECOND: cfg_in.sync_second = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= sfd_pkg::SYNC_FIRST_RST;
         cfg_ff.sync_second <= sfd_pkg::SYNC_SECOND_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sfd_ctrl #(
      .MAX_LEN (MAX_LEN)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .ram_we           (ram_we),
      .ram_re           (ram_re),
      .ram_addr         (ram_addr),
      .ram_rdata        (ram_rdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_frame_length (rsp_frame_length),
      .rsp_has_data     (rsp_has_data),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last)
   );

   sfd_ram #(
      .WIDTH (sfd_pkg::BYTE_W),
      .DEPTH (MAX_LEN)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data (req_rx_byte),
      .rd_en   (ram_re),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   a_ram_excl: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("payload RAM read and write in the same cycle");

   a_read_once: assert property (@(posedge clock) disable iff (reset)
      ram_re |=> !ram_re && !req_ready)
      else $error("replay read not followed by its load cycle");

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      (ram_we || ram_re) |-> (ram_addr < MAX_LEN))
      else $error("payload RAM address out of range");

   a_nodata_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_data) |-> rsp_last)
      else $error("status-only result without last");

endmodule
`default_nettype wire

### rtl/sfd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/sfd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_ctrl
// Frame parser, checksum and payload replay sequencer with result register.
// ----------------------------------------------------------------------------
module sfd_ctrl #(
   parameter int MAX_LEN = sfd_pkg::MAX_LEN_DEFAULT,
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire sfd_pkg::cfg_type           cfg,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [sfd_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                            ram_we,
   output logic                            ram_re,
   output logic [AW-1:0]                   ram_addr,
   input  wire logic [sfd_pkg::BYTE_W-1:0] ram_rdata,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_status,
   output logic [sfd_pkg::BYTE_W-1:0]      rsp_frame_type,
   output logic [sfd_pkg::FLEN_W-1:0]      rsp_frame_length,
   output logic                            rsp_has_data,
   output logic [sfd_pkg::BIDX_W-1:0]      rsp_byte_index,
   output logic [sfd_pkg::BYTE_W-1:0]      rsp_payload_byte,
   output logic                            rsp_last
);

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam logic [sfd_pkg::BYTE_W-1:0] MAX_B = sfd_pkg::BYTE_W'(MAX_LEN);

   sfd_pkg::phase_type phase_ff, phase_in;

   logic [sfd_pkg::BYTE_W-1:0] type_ff, type_in;
   logic [LW-1:0]              len_ff, len_in;
   logic [LW-1:0]              cnt_ff, cnt_in;
   logic [sfd_pkg::BYTE_W-1:0] xor_ff, xor_in;

   logic                       out_valid_ff, out_valid_in;
   logic                       out_status_ff, out_status_in;
   logic [sfd_pkg::BYTE_W-1:0] out_type_ff, out_type_in;
   logic [sfd_pkg::FLEN_W-1:0] out_len_ff, out_len_in;
   logic                       out_has_ff, out_has_in;
   logic [sfd_pkg::BIDX_W-1:0] out_idx_ff, out_idx_in;
   logic [sfd_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic                       out_last_ff, out_last_in;

   logic                       out_free;
   logic                       out_load;
   logic                       acc;
   logic [LW-1:0]              cnt_inc;
   logic                       cnt_done;
   logic [sfd_pkg::BYTE_W-1:0] b;

   assign b        = req_rx_byte;
   assign out_free = !out_valid_ff || rsp_ready;
   assign acc      = req_valid && req_ready;
   assign cnt_inc  = cnt_ff + LW'(1);
   assign cnt_done = (cnt_inc >= len_ff);
   assign ram_addr = cnt_ff[AW-1:0];

   // next state
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         sfd_pkg::PH_SYNC1: begin
            if (acc) begin
               phase_in = (b == cfg.sync_first) ? sfd_pkg::PH_SYNC2 : sfd_pkg::PH_SYNC1;
            end
         end
         sfd_pkg::PH_SYNC2: begin
            if (acc) begin
               if (b == cfg.sync_second) begin
                  phase_in = sfd_pkg::PH_TYPE;
               end else if (b == cfg.sync_first) begin
                  phase_in = sfd_pkg::PH_SYNC2;
               end else begin
                  phase_in = sfd_pkg::PH_SYNC1;
               end
            end
         end
         sfd_pkg::PH_TYPE: begin
            if (acc) begin
               phase_in = sfd_pkg::PH_LEN;
            end
         end
         sfd_pkg::PH_LEN: begin
            if (acc) begin
               if (b > MAX_B) begin
                  phase_in = sfd_pkg::PH_SYNC1;
               end else if (b == '0) begin
                  phase_in = sfd_pkg::PH_CHECK;
               end else begin
                  phase_in = sfd_pkg::PH_PAYLOAD;
               end
            end
         end
         sfd_pkg::PH_PAYLOAD: begin
            if (acc && cnt_done) begin
               phase_in = sfd_pkg::PH_CHECK;
            end
         end
         sfd_pkg::PH_CHECK: begin
            if (acc) begin
               phase_in = (b == xor_ff && len_ff != '0) ? sfd_pkg::PH_READ
                                                       : sfd_pkg::PH_SYNC1;
            end
         end
         sfd_pkg::PH_READ: begin
            phase_in = sfd_pkg::PH_LOAD;
         end
         sfd_pkg::PH_LOAD: begin
            if (out_free) begin
               phase_in = (cnt_inc == len_ff) ? sfd_pkg::PH_SYNC1 : sfd_pkg::PH_READ;
            end
         end
         default: begin
            phase_in = sfd_pkg::PH_SYNC1;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready   = 1'b0;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      out_load    = 1'b0;
      type_in     = type_ff;
      len_in      = len_ff;
      cnt_in      = cnt_ff;
      xor_in      = xor_ff;
      out_status_in = sfd_pkg::STATUS_OK;
      out_type_in   = type_ff;
      out_len_in    = sfd_pkg::FLEN_W'(len_ff);
      out_has_in    = 1'b0;
      out_idx_in    = '0;
      out_byte_in   = '0;
      out_last_in   = 1'b1;
      case (phase_ff)
         sfd_pkg::PH_SYNC1, sfd_pkg::PH_SYNC2: begin
            req_ready = 1'b1;
         end
         sfd_pkg::PH_TYPE: begin
            req_ready = 1'b1;
            if (acc) begin
               type_in = b;
               xor_in  = b;
            end
         end
         sfd_pkg::PH_LEN: begin
            req_ready = 1'b1;
            if (acc) begin
               cnt_in = '0;
               if (b <= MAX_B) begin
                  len_in = b[LW-1:0];
                  xor_in = xor_ff ^ b;
               end
            end
         end
         sfd_pkg::PH_PAYLOAD: begin
            req_ready = 1'b1;
            if (acc) begin
               ram_we = 1'b1;
               xor_in = xor_ff ^ b;
               cnt_in = cnt_inc;
            end
         end
         sfd_pkg::PH_CHECK: begin
            req_ready = out_free;
            if (acc) begin
               cnt_in = '0;
               if (b != xor_ff) begin
                  out_load      = 1'b1;
                  out_status_in = sfd_pkg::STATUS_BAD;
               end else if (len_ff == '0) begin
                  out_load = 1'b1;
               end
            end
         end
         sfd_pkg::PH_READ: begin
            ram_re = 1'b1;
         end
         sfd_pkg::PH_LOAD: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_has_in  = 1'b1;
               out_idx_in  = sfd_pkg::BIDX_W'(cnt_ff);
               out_byte_in = ram_rdata;
               out_last_in = (cnt_inc == len_ff);
               cnt_in      = cnt_inc;
            end
         end
         default: begin
            req_ready = 1'b1;
         end
      endcase
      out_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sfd_pkg::PH_SYNC1;
         out_valid_ff <= 1'b0;
         type_ff      <= '0;
         len_ff       <= '0;
         cnt_ff       <= '0;
         xor_ff       <= '0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
         type_ff      <= type_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         xor_ff       <= xor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_status_ff <= out_status_in;
         out_type_ff   <= out_type_in;
         out_len_ff    <= out_len_in;
         out_has_ff    <= out_has_in;
         out_idx_ff    <= out_idx_in;
         out_byte_ff   <= out_byte_in;
         out_last_ff   <= out_last_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_frame_type   = out_type_ff;
   assign rsp_frame_length = out_len_ff;
   assign rsp_has_data     = out_has_ff;
   assign rsp_byte_index   = out_idx_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_last         = out_last_ff;

endmodule
`default_nettype wire

### tb/sv/tb_sync_frame_decoder_xor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_frame_decoder_xor
// Self-checking bench for the sync frame decoder. Byte transactions go in on
// the req_ channel with random gaps. An in-bench decoder tracks sync hunting,
// header, payload and check byte, and queues the frame results it expects.
// The rsp_ channel is stalled at random, and every result is compared with
// the oldest queued one. Directed frames come first, then random frames,
// broken sequences and noise under several sync byte settings.
// ----------------------------------------------------------------------------
module tb_sync_frame_decoder_xor;

   localparam int FRAME_MAX         = sfd_pkg::MAX_LEN_DEFAULT;
   localparam int QUIET_LIMIT       = 400;
   localparam int DRAIN_CYCLES      = 20;
   localparam int CFG_SETTLE_CYCLES = 8;
   localparam int REPORT_LIMIT      = 10;

   typedef struct packed {
      logic                       status;
      logic [sfd_pkg::BYTE_W-1:0] frame_type;
      logic [sfd_pkg::FLEN_W-1:0] frame_length;
      logic                       has_data;
      logic [sfd_pkg::BIDX_W-1:0] byte_index;
      logic [sfd_pkg::BYTE_W-1:0] payload_byte;
      logic                       last;
   } frame_result_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [sfd_pkg::BYTE_W-1:0]    req_rx_byte = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_status;
   logic [sfd_pkg::BYTE_W-1:0]    rsp_frame_type;
   logic [sfd_pkg::FLEN_W-1:0]    rsp_frame_length;
   logic                          rsp_has_data;
   logic [sfd_pkg::BIDX_W-1:0]    rsp_byte_index;
   logic [sfd_pkg::BYTE_W-1:0]    rsp_payload_byte;
   logic                          rsp_last;
   logic                          csr_we = 1'b0;
   logic [sfd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sfd_pkg::BYTE_W-1:0]    csr_wdata = '0;

   // decoder copy
   logic [sfd_pkg::BYTE_W-1:0] cfg_sync_first  = sfd_pkg::SYNC_FIRST_RST;
   logic [sfd_pkg::BYTE_W-1:0] cfg_sync_second = sfd_pkg::SYNC_SECOND_RST;
   sfd_pkg::phase_type         dec_phase = sfd_pkg::PH_SYNC1;
   logic [sfd_pkg::BYTE_W-1:0] dec_type = '0;
   logic [sfd_pkg::FLEN_W-1:0] dec_length = '0;
   logic [sfd_pkg::FLEN_W-1:0] dec_count = '0;
   logic [sfd_pkg::BYTE_W-1:0] dec_xor = '0;
   logic [sfd_pkg::BYTE_W-1:0] dec_store [FRAME_MAX];

   frame_result_type frame_results [$];

   int  failure_count = 0;
   int  quiet_cycles = 0;
   int  frame_bytes_sent = 0;
   bit  tx_steady = 1'b0;
   bit  rx_steady = 1'b0;

   sync_frame_decoder_xor DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_frame_length (rsp_frame_length),
      .rsp_has_data     (rsp_has_data),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void push_result(input logic status, input logic has_data,
                                       input logic [sfd_pkg::BIDX_W-1:0] idx,
                                       input logic [sfd_pkg::BYTE_W-1:0] data,
                                       input logic last);
      frame_result_type r;
      r.status       = status;
      r.frame_type   = dec_type;
      r.frame_length = dec_length;
      r.has_data     = has_data;
      r.byte_index   = idx;
      r.payload_byte = data;
      r.last         = last;
      frame_results.push_back(r);
   endfunction

   function automatic void decode_rx_byte(input logic [sfd_pkg::BYTE_W-1:0] rx);
      int i;
      case (dec_phase)
         sfd_pkg::PH_SYNC2: begin
            if (rx == cfg_sync_second)
               dec_phase = sfd_pkg::PH_TYPE;
            else if (rx == cfg_sync_first)
               dec_phase = sfd_pkg::PH_SYNC2;
            else
               dec_phase = sfd_pkg::PH_SYNC1;
         end
         sfd_pkg::PH_TYPE: begin
            dec_type  = rx;
            dec_xor   = rx;
            dec_phase = sfd_pkg::PH_LEN;
         end
         sfd_pkg::PH_LEN: begin
            dec_count = '0;
            if (rx > FRAME_MAX) begin
               dec_phase = sfd_pkg::PH_SYNC1;
            end else begin
               dec_length = rx[sfd_pkg::FLEN_W-1:0];
               dec_xor    = dec_xor ^ rx;
               dec_phase  = (rx == 0) ? sfd_pkg::PH_CHECK : sfd_pkg::PH_PAYLOAD;
            end
         end
         sfd_pkg::PH_PAYLOAD: begin
            if (dec_count < FRAME_MAX)
               dec_store[dec_count[sfd_pkg::BIDX_W-1:0]] = rx;
            dec_xor   = dec_xor ^ rx;
            dec_count = dec_count + 1'b1;
            if (dec_count >= dec_length)
               dec_phase = sfd_pkg::PH_CHECK;
         end
         sfd_pkg::PH_CHECK: begin
            dec_phase = sfd_pkg::PH_SYNC1;
            if (rx != dec_xor) begin
               push_result(sfd_pkg::STATUS_BAD, 1'b0, '0, '0, 1'b1);
            end else if (dec_length == 0) begin
               push_result(sfd_pkg::STATUS_OK, 1'b0, '0, '0, 1'b1);
            end else begin
               for (i = 0; i < dec_length && i < FRAME_MAX; i++)
                  push_result(sfd_pkg::STATUS_OK, 1'b1, i[sfd_pkg::BIDX_W-1:0],
                              dec_store[i[sfd_pkg::BIDX_W-1:0]],
                              (i + 1 == dec_length));
            end
         end
         default: begin
            dec_phase = (rx == cfg_sync_first) ? sfd_pkg::PH_SYNC2 : sfd_pkg::PH_SYNC1;
         end
      endcase
   endfunction

   function automatic string fmt_result(input frame_result_type r);
      return $sformatf("status=%0d type=%02h len=%0d has=%0d idx=%0d data=%02h last=%0d",
                       r.status, r.frame_type, r.frame_length, r.has_data,
                       r.byte_index, r.payload_byte, r.last);
   endfunction

   task automatic note_failure(input string msg);
      failure_count++;
      if (failure_count <= REPORT_LIMIT)
         $display("%0t: %s", $realtime, msg);
   endtask

   // result checker
   always @(posedge clock) begin : result_check
      frame_result_type got;
      frame_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status       = rsp_status;
         got.frame_type   = rsp_frame_type;
         got.frame_length = rsp_frame_length;
         got.has_data     = rsp_has_data;
         got.byte_index   = rsp_byte_index;
         got.payload_byte = rsp_payload_byte;
         got.last         = rsp_last;
         if (frame_results.size() == 0) begin
            note_failure({"unexpected result: ", fmt_result(got)});
         end else begin
            want = frame_results.pop_front();
            if (got !== want)
               note_failure({"mismatch: expected ", fmt_result(want),
                             " actual ", fmt_result(got)});
         end
      end
   end

   // result sink with random stalls
   initial begin : rsp_sink
      int stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = rx_steady ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("tb_sync_frame_decoder_xor failed");
      $finish;
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_rx_byte(input logic [sfd_pkg::BYTE_W-1:0] rx);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (!req_ready);
      decode_rx_byte(rx);
      @(negedge clock);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (frame_results.size() != 0);
   endtask

   task automatic wait_idle();
      wait_results_drained();
      repeat (CFG_SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_sync_bytes(input logic [sfd_pkg::BYTE_W-1:0] first,
                                   input logic [sfd_pkg::BYTE_W-1:0] second);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= sfd_pkg::CSR_SYNC_FIRST;
      csr_wdata <= first;
      @(negedge clock);
      csr_index <= sfd_pkg::CSR_SYNC_SECOND;
      csr_wdata <= second;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_sync_first  = first;
      cfg_sync_second = second;
      @(negedge clock);
   endtask

   // a length above FRAME_MAX ends the frame after the length byte
   task automatic send_frame(input logic [sfd_pkg::BYTE_W-1:0] ftype,
                             input logic [sfd_pkg::BYTE_W-1:0] flen, input bit corrupt);
      logic [sfd_pkg::BYTE_W-1:0] chk;
      logic [sfd_pkg::BYTE_W-1:0] pb;
      int i;
      send_rx_byte(cfg_sync_first);
      send_rx_byte(cfg_sync_second);
      send_rx_byte(ftype);
      send_rx_byte(flen);
      frame_bytes_sent += 4;
      if (flen <= FRAME_MAX) begin
         chk = ftype ^ flen;
         for (i = 0; i < flen; i++) begin
            pb  = sfd_pkg::BYTE_W'($urandom_range(0, 255));
            chk = chk ^ pb;
            send_rx_byte(pb);
         end
         if (corrupt)
            chk = chk ^ sfd_pkg::BYTE_W'($urandom_range(1, 255));
         send_rx_byte(chk);
         frame_bytes_sent += int'(flen) + 1;
      end
   endtask

   task automatic test_empty_frame();
      send_rx_byte(sfd_pkg::SYNC_FIRST_RST);
      send_rx_byte(sfd_pkg::SYNC_SECOND_RST);
      send_rx_byte(8'h00);
      send_rx_byte(8'h00);
      send_rx_byte(8'h00);
      wait_idle();
   endtask

   task automatic test_bad_checksum();
      send_rx_byte(sfd_pkg::SYNC_FIRST_RST);
      send_rx_byte(sfd_pkg::SYNC_SECOND_RST);
      send_rx_byte(8'hFF);
      send_rx_byte(8'h01);
      send_rx_byte(8'hFF);
      send_rx_byte(~(8'hFF ^ 8'h01 ^ 8'hFF));
      wait_idle();
   endtask

   task automatic test_repeated_first_sync();
      send_rx_byte(sfd_pkg::SYNC_FIRST_RST);
      send_rx_byte(sfd_pkg::SYNC_FIRST_RST);
      send_rx_byte(sfd_pkg::SYNC_SECOND_RST);
      send_rx_byte(8'h3C);
      send_rx_byte(8'h02);
      send_rx_byte(8'h00);
      send_rx_byte(8'hFF);
      send_rx_byte(8'h3C ^ 8'h02 ^ 8'h00 ^ 8'hFF);
      wait_idle();
   endtask

   task automatic test_oversize_length();
      send_rx_byte(sfd_pkg::SYNC_FIRST_RST);
      send_rx_byte(sfd_pkg::SYNC_SECOND_RST);
      send_rx_byte(8'h12);
      send_rx_byte(8'(FRAME_MAX + 1));
      wait_idle();
   endtask

   task automatic test_full_payload();
      send_frame(sfd_pkg::BYTE_W'($urandom_range(0, 255)),
                 sfd_pkg::BYTE_W'(FRAME_MAX), 1'b0);
      wait_idle();
   endtask

   task automatic test_random_frames(input int quota, input bit steady);
      int start;
      int kind;
      int flen;
      int n;
      tx_steady = steady;
      rx_steady = steady;
      start = frame_bytes_sent;
      while (frame_bytes_sent - start < quota) begin
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            n = $urandom_range(0, 99);
            if (n < 15)
               flen = 0;
            else if (n < 75)
               flen = $urandom_range(1, 6);
            else if (n < 95)
               flen = $urandom_range(7, FRAME_MAX - 1);
            else
               flen = FRAME_MAX;
            send_frame(sfd_pkg::BYTE_W'($urandom_range(0, 255)), sfd_pkg::BYTE_W'(flen),
                       $urandom_range(0, 7) == 0);
         end else if (kind < 85) begin
            send_frame(sfd_pkg::BYTE_W'($urandom_range(0, 255)),
                       sfd_pkg::BYTE_W'($urandom_range(FRAME_MAX + 1, 255)), 1'b0);
         end else begin
            // broken header or line noise
            if ($urandom_range(0, 1))
               send_rx_byte(cfg_sync_first);
            repeat ($urandom_range(1, 4))
               send_rx_byte(sfd_pkg::BYTE_W'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 3) == 0)
            wait_results_drained();
      end
      wait_idle();
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   task automatic test_sync_settings();
      write_sync_bytes(8'h00, 8'hFF);
      test_random_frames(1, 1'b0);
      write_sync_bytes(8'hFF, 8'h00);
      test_random_frames(1, 1'b0);
      write_sync_bytes(8'h5A, 8'h5A);
      test_random_frames(1, 1'b0);
      write_sync_bytes(sfd_pkg::SYNC_FIRST_RST, sfd_pkg::SYNC_SECOND_RST);
   endtask

   initial begin : test_sequence
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_frame();
      test_bad_checksum();
      test_repeated_first_sync();
      test_oversize_length();
      test_random_frames(6, 1'b0);
      test_random_frames(1, 1'b1);
      test_full_payload();
      test_sync_settings();

      wait_results_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (frame_results.size() != 0)
         note_failure($sformatf("%0d expected results never arrived",
                                frame_results.size()));
      if (failure_count == 0)
         $display("tb_sync_frame_decoder_xor passed");
      else
         $display("tb_sync_frame_decoder_xor failed");
      $finish;
   end

endmodule

### filelist.f
rtl/sfd_pkg.sv
rtl/sfd_ram.sv
rtl/sfd_ctrl.sv
rtl/sync_frame_decoder_xor.sv
tb/sv/tb_sync_frame_decoder_xor.sv
